// ===== design/ptc_pkg.sv =====
package ptc_pkg;

    typedef enum logic [2:0] {
        REG_OSS   = 3'd0,
        REG_TEMP  = 3'd1,
        REG_AC1   = 3'd2,
        REG_AC2   = 3'd3,
        REG_AC3   = 3'd4,
        REG_AC4   = 3'd5,
        REG_B1    = 3'd6,
        REG_B2    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]         oss;
        logic [15:0]        ac5;
        logic [15:0]        ac6;
        logic signed [15:0] mc;
        logic signed [15:0] md;
        logic signed [15:0] ac1;
        logic signed [15:0] ac2;
        logic signed [15:0] ac3;
        logic [15:0]        ac4;
        logic signed [15:0] b1;
        logic signed [15:0] b2;
    } coeffs_t;

    localparam coeffs_t CAL_RESET = {2'd1, 160'd0};

    localparam int QW = 33;
    localparam int DIVW = 32;

endpackage

// ===== design/ptc_div.sv =====
module ptc_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [31:0]         in_num,
    input  logic [31:0]         in_den,
    input  logic [63:0]         in_side,
    output logic                out_valid,
    output logic [31:0]         out_quot,
    output logic [63:0]         out_side
);
    import ptc_pkg::*;

    logic [DIVW:0]      vld_reg;
    logic [31:0]        num_reg  [DIVW+1];
    logic [31:0]        den_reg  [DIVW+1];
    logic [31:0]        quo_reg  [DIVW+1];
    logic [31:0]        rem_reg  [DIVW+1];
    logic [63:0]        side_reg [DIVW+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[DIVW-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg[0]  <= in_num;
            den_reg[0]  <= in_den;
            quo_reg[0]  <= '0;
            rem_reg[0]  <= '0;
            side_reg[0] <= in_side;
        end
    end

    for (genvar i = 0; i < DIVW; i++)
    begin : g_step
        logic [32:0] trial;
        logic [32:0] shifted;
        assign shifted = {rem_reg[i], num_reg[i][31 - i]};
        assign trial   = shifted - {1'b0, den_reg[i]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[i+1]  <= num_reg[i];
                den_reg[i+1]  <= den_reg[i];
                side_reg[i+1] <= side_reg[i];
                if (!trial[32])
                begin
                    rem_reg[i+1] <= trial[31:0];
                    quo_reg[i+1] <= {quo_reg[i][30:0], 1'b1};
                end
                else
                begin
                    rem_reg[i+1] <= shifted[31:0];
                    quo_reg[i+1] <= {quo_reg[i][30:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = vld_reg[DIVW];
    assign out_quot  = quo_reg[DIVW];
    assign out_side  = side_reg[DIVW];

endmodule

// ===== design/ptc_cfg.sv =====
module ptc_cfg
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [2:0]            cfg_index,
    input  logic [63:0]           cfg_data,
    output ptc_pkg::coeffs_t      coeffs
);
    import ptc_pkg::*;

    coeffs_t c_reg;

    assign cfg_ready = 1'b1;
    assign coeffs    = c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg <= CAL_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (reg_idx_t'(cfg_index))
                REG_OSS:  c_reg.oss <= cfg_data[1:0];
                REG_TEMP:
                begin
                    c_reg.ac5 <= cfg_data[63:48];
                    c_reg.ac6 <= cfg_data[47:32];
                    c_reg.mc  <= cfg_data[31:16];
                    c_reg.md  <= cfg_data[15:0];
                end
                REG_AC1:  c_reg.ac1 <= cfg_data[15:0];
                REG_AC2:  c_reg.ac2 <= cfg_data[15:0];
                REG_AC3:  c_reg.ac3 <= cfg_data[15:0];
                REG_AC4:  c_reg.ac4 <= cfg_data[15:0];
                REG_B1:   c_reg.b1  <= cfg_data[15:0];
                REG_B2:   c_reg.b2  <= cfg_data[15:0];
                default:  c_reg.oss <= c_reg.oss;
            endcase
        end
    end

endmodule

// ===== design/pressure_temperature_compensation.sv =====
// Pressure and temperature compensation pipeline.
// Input requests on s_axis carry raw_temp and raw_press; one result request
// leaves on m_axis for each input, in order. Calibration registers are
// written through the cfg channel, which is always ready; the user must
// write them only while idle, as the block does not enforce it. The
// pipeline is 73 register stages deep, set mostly by two restoring dividers
// of an input register and 32 one-bit stages each (temperature divide, then
// the pressure divide). One request enters every cycle when m_axis is ready
// or holds no result.
// When the receiver stalls, the whole pipeline holds; s_axis_tready falls
// only while the final output register holds an untaken result, so nothing
// is lost or repeated.
// Reset clears all valid bits, sets oversampling to 1 and the coefficients
// to zero. Division by zero gives status 1 with zero results.
module pressure_temperature_compensation
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // raw_temp[15:0], raw_press[39:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,  // temp_tenths[15:0], press_pa[33:16]
    output logic [0:0]  m_axis_tuser   // status[0]
);
    import ptc_pkg::*;

    coeffs_t cf;
    logic    en;

    ptc_cfg u_cfg
    (
        .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .coeffs(cf)
    );

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // Stage 1: X1 product.
    logic               v1_reg;
    logic signed [33:0] p1_reg;
    logic [23:0]        up1_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v1_reg <= 1'b0;
        else if (en) v1_reg <= s_axis_tvalid;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg  <= ($signed({18'd0, s_axis_tdata[15:0]}) - $signed({18'd0, cf.ac6}))
                       * $signed({18'd0, cf.ac5});
            up1_reg <= s_axis_tdata[39:16] >> (4'd8 - {2'd0, cf.oss});
        end
    end

    // Stage 2: X1 and divisor; sign-magnitude into divider.
    logic signed [18:0] x1_2;
    logic signed [19:0] den2;
    logic [31:0]        num_mag, den_mag;
    logic signed [27:0] mcs;
    assign x1_2    = 19'(p1_reg >>> 15);
    assign den2    = 20'(x1_2) + 20'(cf.md);
    assign mcs     = 28'(cf.mc) <<< 11;
    assign num_mag = mcs[27] ? 32'(-mcs) : 32'(mcs);
    assign den_mag = den2[19] ? 32'(-den2) : 32'(den2);

    logic        vd1;
    logic [31:0] q1;
    logic [63:0] sd1;
    ptc_div u_div1
    (
        .clk, .rst_n, .en, .in_valid(v1_reg), .in_num(num_mag), .in_den(den_mag),
        .in_side({up1_reg, x1_2, (mcs[27] ^ den2[19]), (den2 == 20'sd0), 19'd0}),
        .out_valid(vd1), .out_quot(q1), .out_side(sd1)
    );

    // Stage 3: B5 and B6.
    logic               v3_reg, z3_reg;
    logic signed [31:0] b5_3_reg;
    logic [23:0]        up3_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v3_reg <= 1'b0;
        else if (en) v3_reg <= vd1;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b5_3_reg <= 32'(signed'(sd1[39:21])) + (sd1[20] ? -$signed(q1) : $signed(q1));
            z3_reg   <= sd1[19];
            up3_reg  <= sd1[63:40];
        end
    end

    logic signed [31:0] b6_3;
    assign b6_3 = b5_3_reg - 32'sd4000;

    // Stage 4: b6 squared and linear terms.
    logic               v4_reg, z4_reg;
    logic signed [31:0] b5_4_reg, a2_4_reg, a3_4_reg;
    logic signed [47:0] sq4_reg;
    logic [23:0]        up4_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v4_reg <= 1'b0;
        else if (en) v4_reg <= v3_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b5_4_reg <= b5_3_reg;
            z4_reg   <= z3_reg;
            up4_reg  <= up3_reg;
            sq4_reg  <= 48'((64'(b6_3) * 64'(b6_3)) >>> 12);
            a2_4_reg <= 32'((64'(b6_3) * 64'(cf.ac2)) >>> 11);
            a3_4_reg <= 32'((64'(b6_3) * 64'(cf.ac3)) >>> 13);
        end
    end

    // Stage 5: b2/b1 products, b3 and x3.
    logic               v5_reg, z5_reg;
    logic signed [31:0] b5_5_reg, b3_5_reg, x3_5_reg;
    logic [23:0]        up5_reg;
    logic signed [63:0] t_b2, t_b1;
    logic signed [63:0] b3n;
    assign t_b2 = (64'(sq4_reg) * 64'(cf.b2)) >>> 11;
    assign t_b1 = (64'(sq4_reg) * 64'(cf.b1)) >>> 16;
    assign b3n  = (((64'(cf.ac1) <<< 2) + t_b2 + 64'(a2_4_reg)) <<< cf.oss) + 64'sd2;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v5_reg <= 1'b0;
        else if (en) v5_reg <= v4_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b5_5_reg <= b5_4_reg;
            z5_reg   <= z4_reg;
            up5_reg  <= up4_reg;
            b3_5_reg <= 32'(b3n[63] ? -((-b3n) >>> 2) : (b3n >>> 2));
            x3_5_reg <= 32'((64'(a3_4_reg) + t_b1 + 64'sd2) >>> 2);
        end
    end

    // Stage 6: b4 and b7.
    logic               v6_reg, z6_reg;
    logic signed [31:0] b5_6_reg;
    logic [31:0]        b4_6_reg, b7_6_reg;
    logic [31:0]        x3u, dup;
    logic [63:0]        b4p, b7p;
    assign x3u = 32'(x3_5_reg + 32'sd32768);
    assign dup = 32'({8'd0, up5_reg}) - 32'(b3_5_reg);
    assign b4p = 64'(x3u) * 64'(cf.ac4);
    assign b7p = 64'(dup) * 64'(17'd50000 >> cf.oss);
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v6_reg <= 1'b0;
        else if (en) v6_reg <= v5_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b5_6_reg <= b5_5_reg;
            b4_6_reg <= {15'd0, b4p[31:15]};
            b7_6_reg <= b7p[31:0];
            z6_reg   <= z5_reg || (b4p[31:15] == 17'd0);
        end
    end

    logic        vd2;
    logic [31:0] q2;
    logic [63:0] sd2;
    logic        hi7;
    assign hi7 = b7_6_reg[31];
    ptc_div u_div2
    (
        .clk, .rst_n, .en, .in_valid(v6_reg),
        .in_num(hi7 ? b7_6_reg : {b7_6_reg[30:0], 1'b0}),
        .in_den(z6_reg ? 32'd1 : b4_6_reg),
        .in_side({b5_6_reg, 30'd0, hi7, z6_reg}),
        .out_valid(vd2), .out_quot(q2), .out_side(sd2)
    );

    // Stage 7: p and second-order squares.
    logic               v7_reg, z7_reg;
    logic signed [31:0] b5_7_reg;
    logic signed [QW:0] p7_reg;
    logic signed [49:0] sq7_reg;
    logic signed [47:0] l7_reg;
    logic signed [QW:0] pq;
    logic signed [QW:0] ps;
    assign pq = sd2[1] ? $signed({2'd0, q2[30:0], 1'b0}) : $signed({2'd0, q2});
    assign ps = pq >>> 8;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) v7_reg <= 1'b0;
        else if (en) v7_reg <= vd2;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b5_7_reg <= sd2[63:32];
            z7_reg   <= sd2[0];
            p7_reg   <= pq;
            sq7_reg  <= 50'(ps) * 50'(ps);
            l7_reg   <= (48'(pq) * -48'sd7357) >>> 16;
        end
    end

    // Stage 8: final sum and saturation into the output register.
    logic signed [63:0] c3;
    logic signed [63:0] pf;
    logic signed [31:0] tt;
    logic [17:0]        pout;
    logic [15:0]        tout;
    assign c3 = (64'(sq7_reg) * 64'sd3038) >>> 16;
    assign pf = 64'(p7_reg) + ((c3 + 64'(l7_reg) + 64'sd3791) >>> 4);
    assign tt = (b5_7_reg + 32'sd8) >>> 4;
    always_comb
    begin
        if (pf < 0) pout = '0;
        else if (pf > 64'sd262143) pout = 18'h3FFFF;
        else pout = pf[17:0];
        if (tt > 32'sd32767) tout = 16'h7FFF;
        else if (tt < -32'sd32768) tout = 16'h8000;
        else tout = tt[15:0];
    end

    logic        ov_reg;
    logic [34:0] od_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) ov_reg <= 1'b0;
        else if (en) ov_reg <= v7_reg;
    end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            od_reg <= z7_reg ? {1'b1, 34'd0} : {1'b0, pout, tout};
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {6'd0, od_reg[33:0]};
    assign m_axis_tuser  = od_reg[34];

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[33:0] == 34'd0)
        else $error("status set with nonzero result");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready mismatch");

endmodule
